FILE: src/ptds_pkg.sv
// Package for the 1-D Poisson tridiagonal solver.
// Holds shared types and register codes; no dependencies.
package ptds_pkg;

    localparam int unsigned WORD_W = 32;

    // configuration register indexes
    localparam logic [1:0] CFG_LEFT  = 2'd0;
    localparam logic [1:0] CFG_RIGHT = 2'd1;
    localparam logic [1:0] CFG_INV   = 2'd2;

    localparam logic [WORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_MIN = 32'h8000_0000;

    // saturated 32-bit value plus its overflow mark
    typedef struct packed {
        logic [WORD_W-1:0] v;
        logic              f;
    } t_sat32;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_FRD  = 11'b000_0000_0010,
        S_FMUL = 11'b000_0000_0100,
        S_DIVS = 11'b000_0000_1000,
        S_DIVW = 11'b000_0001_0000,
        S_BRD  = 11'b000_0010_0000,
        S_BMUL = 11'b000_0100_0000,
        S_BSUB = 11'b000_1000_0000,
        S_ERD  = 11'b001_0000_0000,
        S_ELD  = 11'b010_0000_0000,
        S_EWT  = 11'b100_0000_0000
    } t_state;

endpackage

FILE: src/poisson_1d_tridiagonal_solver_unit.sv
// Top level of the 1-D Poisson tridiagonal solver (Thomas algorithm).
// Depends on ptds_pkg, ptds_ram and ptds_div.
//
//  channel | direction | handshake                   | word
//  --------+-----------+-----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready     | permittivity, source_value, last_node
//  out     | output    | o_out_valid / i_out_ready   | potential, last_potential, fault
//  cfg     | input     | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// A non-final word is stored. The final word starts the solve: each interior row
// reads its permittivities and source in S_FRD, then takes 9 multiply steps on
// the one shared multiplier (an end row skips the reads and starts at the products
// with the previous row) and two serial divisions; back substitution runs BRD,
// BMUL and BSUB per node and emission ERD, ELD and EWT per word plus any output
// stall. Ready is low for the whole solve and emission. Reset is synchronous and
// active low; the stores need no clearing since only written entries are read.
module poisson_1d_tridiagonal_solver_unit #(
    parameter int unsigned MAX_NODES = 64,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_permittivity,
    input  logic [31:0] i_source_value,
    input  logic        i_last_node,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_potential,
    output logic        o_last_potential,
    output logic        o_numeric_fault,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ptds_pkg::*;

    localparam int unsigned AW = $clog2(MAX_NODES);
    localparam int unsigned CW = $clog2(MAX_NODES + 1);
    localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

    // ---------------- state ----------------
    t_state        r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_i;
    logic [1:0]    r_ph;
    logic [3:0]    r_step;
    logic          r_dsel;
    logic          r_end;
    logic          r_fault;

    logic [31:0] r_left, r_right, r_inv;

    logic [31:0] r_pm, r_pc, r_pp;
    logic [31:0] r_r, r_a, r_b, r_c, r_den, r_num, r_cp, r_dp, r_next, r_rhs_i;
    logic signed [65:0] r_prod;
    logic [66:0]        r_acc;

    logic        r_out_valid;
    logic [31:0] r_pot;
    logic        r_olast;
    logic        r_ofault;

    // ---------------- memories ----------------
    logic          in_acc;
    logic          store_ok;
    logic [AW-1:0] p_raddr;
    logic [31:0]   p_rdata, s_rdata, ratio_rdata, rhs_rdata;
    logic          ratio_we, rhs_we;
    logic [31:0]   rhs_wdata;
    logic [CW-1:0] i_m1, i_p1;

    assign in_acc   = i_in_valid && o_in_ready;
    assign store_ok = r_count < CW'(MAX_NODES);
    assign i_m1     = r_i - CW'(1);
    assign i_p1     = r_i + CW'(1);

    always_comb begin
        case (r_ph)
            2'd0:    p_raddr = i_m1[AW-1:0];
            2'd1:    p_raddr = r_i[AW-1:0];
            default: p_raddr = i_p1[AW-1:0];
        endcase
    end

    ptds_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_perm (
        .i_clk(i_clk), .i_we(in_acc && store_ok), .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_permittivity), .i_raddr(p_raddr), .o_rdata(p_rdata)
    );
    ptds_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_src (
        .i_clk(i_clk), .i_we(in_acc && store_ok), .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_source_value), .i_raddr(r_i[AW-1:0]), .o_rdata(s_rdata)
    );
    ptds_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_ratio (
        .i_clk(i_clk), .i_we(ratio_we), .i_waddr(r_i[AW-1:0]),
        .i_wdata(r_cp), .i_raddr(r_i[AW-1:0]), .o_rdata(ratio_rdata)
    );
    ptds_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_rhs (
        .i_clk(i_clk), .i_we(rhs_we), .i_waddr(r_i[AW-1:0]),
        .i_wdata(rhs_wdata), .i_raddr(r_i[AW-1:0]), .o_rdata(rhs_rdata)
    );

    // ---------------- arithmetic helpers ----------------
    // floor(s / 2^FRAC_BITS), saturated, optionally negated
    function automatic t_sat32 f_coef(input logic [66:0] s, input logic neg);
        logic [66:0] q;
        t_sat32      res;
        q     = s >> FRAC_BITS;
        res.f = 1'b0;
        if (neg) begin
            if (q > 67'd2147483648) begin
                res.v = SAT_MIN;
                res.f = 1'b1;
            end else begin
                res.v = ~q[31:0] + 32'd1;
            end
        end else if (q > 67'd2147483647) begin
            res.v = SAT_MAX;
            res.f = 1'b1;
        end else begin
            res.v = q[31:0];
        end
        return res;
    endfunction

    // a - s, saturated to 32 bits
    function automatic t_sat32 f_sub_sat(input logic [31:0] a, input logic [65:0] s);
        logic [66:0] d;
        t_sat32      res;
        d     = {{35{a[31]}}, a} - {s[65], s};
        res.f = 1'b0;
        res.v = d[31:0];
        if (d[66] && (d[65:31] != '1)) begin
            res.v = SAT_MIN;
            res.f = 1'b1;
        end else if (!d[66] && (d[65:31] != '0)) begin
            res.v = SAT_MAX;
            res.f = 1'b1;
        end
        return res;
    endfunction

    // permittivity sums for the three coefficients of an interior row
    logic [33:0] sum_a, sum_b, sum_c;
    assign sum_a = {2'b0, r_pm} + {2'b0, r_pc};
    assign sum_b = {2'b0, r_pm} + {1'b0, r_pc, 1'b0} + {2'b0, r_pp};
    assign sum_c = {2'b0, r_pc} + {2'b0, r_pp};

    // shared multiplier operand select
    logic signed [32:0] mul_x, mul_y;
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (r_state)
            S_FMUL: begin
                mul_y = {1'b0, r_inv};
                case (r_step)
                    4'd0:    mul_x = {15'b0, sum_a[33:16]};
                    4'd1:    mul_x = {17'b0, sum_a[15:0]};
                    4'd2:    mul_x = {15'b0, sum_b[33:16]};
                    4'd3:    mul_x = {17'b0, sum_b[15:0]};
                    4'd4:    mul_x = {15'b0, sum_c[33:16]};
                    4'd5:    mul_x = {17'b0, sum_c[15:0]};
                    4'd6: begin
                        mul_x = {r_a[31], r_a};
                        mul_y = {r_cp[31], r_cp};
                    end
                    4'd7: begin
                        mul_x = {r_a[31], r_a};
                        mul_y = {r_dp[31], r_dp};
                    end
                    default: mul_x = '0;
                endcase
            end
            S_BMUL: begin
                mul_x = {ratio_rdata[31], ratio_rdata};
                mul_y = {r_next[31], r_next};
            end
            default: mul_x = '0;
        endcase
    end

    logic [66:0]        acc_sum;
    logic signed [65:0] prod_sh;
    t_sat32             coef_pos, coef_neg, den_s, num_s, back_s;

    assign acc_sum  = r_acc + {1'b0, r_prod};
    assign prod_sh  = r_prod >>> FRAC_BITS;
    assign coef_pos = f_coef(acc_sum, 1'b0);
    assign coef_neg = f_coef(acc_sum, 1'b1);
    assign den_s    = f_sub_sat(r_b, prod_sh);
    assign num_s    = f_sub_sat(r_r, prod_sh);
    assign back_s   = f_sub_sat(r_rhs_i, prod_sh);

    // ---------------- division control ----------------
    logic [31:0] div_num;
    logic        den_zero;
    logic        div_start;
    logic        div_done;
    logic [31:0] div_quot;
    logic        div_sat;
    logic        res_ok;
    logic [31:0] res_val;
    logic        res_fault;
    logic [31:0] zp_val;

    assign div_num   = r_dsel ? r_num : r_c;
    assign den_zero  = (r_den == '0);
    assign div_start = (r_state == S_DIVS) && !den_zero;
    assign zp_val    = div_num[31] ? SAT_MIN : ((div_num != '0) ? SAT_MAX : '0);
    assign res_ok    = ((r_state == S_DIVS) && den_zero) || ((r_state == S_DIVW) && div_done);
    assign res_val   = (r_state == S_DIVS) ? zp_val : div_quot;
    assign res_fault = (r_state == S_DIVS) ? 1'b1 : div_sat;

    ptds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(r_den),
        .o_done(div_done), .o_quot(div_quot), .o_sat(div_sat)
    );

    assign ratio_we  = res_ok && r_dsel;
    assign rhs_we    = (res_ok && r_dsel) || (r_state == S_BSUB);
    assign rhs_wdata = (r_state == S_BSUB) ? back_s.v : res_val;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_x * mul_y;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_fault     <= 1'b0;
            r_dsel      <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_right     <= '0;
            r_inv       <= ONE_Q;
            r_cp        <= '0;
            r_dp        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LEFT:  r_left  <= i_cfg_data;
                    CFG_RIGHT: r_right <= i_cfg_data;
                    CFG_INV:   r_inv   <= i_cfg_data;
                    default:   ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        // drop the word when the store is full
                        if (store_ok) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_fault <= 1'b1;
                        end
                        if (i_last_node) begin
                            r_n     <= store_ok ? r_count + CW'(1) : r_count;
                            r_i     <= '0;
                            r_ph    <= 2'd0;
                            r_state <= S_FRD;
                        end
                    end
                end
                S_FRD: begin
                    case (r_ph)
                        2'd0: begin
                            if ((r_i == '0) || (r_i == r_n - CW'(1))) begin
                                // end row pins the potential
                                r_a     <= '0;
                                r_b     <= ONE_Q;
                                r_c     <= '0;
                                r_r     <= (r_i == r_n - CW'(1)) ? r_right : r_left;
                                r_end   <= 1'b1;
                                r_step  <= 4'd6;
                                r_state <= S_FMUL;
                            end else begin
                                r_end <= 1'b0;
                                r_ph  <= 2'd1;
                            end
                        end
                        2'd1: begin
                            r_pm <= p_rdata;
                            r_r  <= s_rdata;
                            r_ph <= 2'd2;
                        end
                        2'd2: begin
                            r_pc <= p_rdata;
                            r_ph <= 2'd3;
                        end
                        default: begin
                            r_pp    <= p_rdata;
                            r_step  <= 4'd0;
                            r_state <= S_FMUL;
                        end
                    endcase
                end
                S_FMUL: begin
                    r_step <= r_step + 4'd1;
                    case (r_step)
                        4'd1, 4'd3, 4'd5: r_acc <= {r_prod[50:0], 16'b0};
                        4'd2: begin
                            r_a     <= coef_pos.v;
                            r_fault <= r_fault | coef_pos.f;
                        end
                        4'd4: begin
                            r_b     <= coef_neg.v;
                            r_fault <= r_fault | coef_neg.f;
                        end
                        4'd6: begin
                            if (!r_end) begin
                                r_c     <= coef_pos.v;
                                r_fault <= r_fault | coef_pos.f;
                            end
                        end
                        4'd7: begin
                            r_den   <= den_s.v;
                            r_fault <= r_fault | den_s.f;
                        end
                        4'd8: begin
                            r_num   <= num_s.v;
                            r_fault <= r_fault | num_s.f;
                            r_dsel  <= 1'b0;
                            r_state <= S_DIVS;
                        end
                        default: ;
                    endcase
                end
                S_DIVS, S_DIVW: begin
                    if (res_ok) begin
                        r_fault <= r_fault | res_fault;
                        if (!r_dsel) begin
                            r_cp    <= res_val;
                            r_dsel  <= 1'b1;
                            r_state <= S_DIVS;
                        end else begin
                            r_dp   <= res_val;
                            r_dsel <= 1'b0;
                            if (r_i == r_n - CW'(1)) begin
                                r_next <= res_val;
                                if (r_n == CW'(1)) begin
                                    r_i     <= '0;
                                    r_state <= S_ERD;
                                end else begin
                                    r_i     <= r_i - CW'(1);
                                    r_state <= S_BRD;
                                end
                            end else begin
                                r_i     <= r_i + CW'(1);
                                r_ph    <= 2'd0;
                                r_state <= S_FRD;
                            end
                        end
                    end else if (r_state == S_DIVS) begin
                        r_state <= S_DIVW;
                    end
                end
                S_BRD: r_state <= S_BMUL;
                S_BMUL: begin
                    r_rhs_i <= rhs_rdata;
                    r_state <= S_BSUB;
                end
                S_BSUB: begin
                    r_next  <= back_s.v;
                    r_fault <= r_fault | back_s.f;
                    if (r_i == '0) begin
                        r_state <= S_ERD;
                    end else begin
                        r_i     <= r_i - CW'(1);
                        r_state <= S_BRD;
                    end
                end
                S_ERD: r_state <= S_ELD;
                S_ELD: begin
                    r_pot       <= rhs_rdata;
                    r_olast     <= (r_i == r_n - CW'(1));
                    r_ofault    <= r_fault;
                    r_out_valid <= 1'b1;
                    r_state     <= S_EWT;
                end
                S_EWT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_olast) begin
                            // solve done: clear for the next mesh
                            r_count <= '0;
                            r_fault <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_potential      = r_pot;
    assign o_last_potential = r_olast;
    assign o_numeric_fault  = r_ofault;
endmodule

FILE: src/ptds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptds_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/ptds_div.sv
// Serial restoring divider: (num << FRAC_BITS) / den, truncated, saturated.
// Depends on ptds_pkg. One quotient bit per cycle.
module ptds_div #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic        o_sat
);
    import ptds_pkg::*;

    localparam int unsigned NW = WORD_W + FRAC_BITS;
    localparam int unsigned CNW = $clog2(NW + 1);

    logic [NW-1:0]  r_dvd;
    logic [31:0]    r_rem;
    logic [31:0]    r_dvs;
    logic           r_neg;
    logic [CNW-1:0] r_cnt;
    logic           r_done;

    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic [32:0] rem_sh;
    logic        take;
    logic [32:0] rem_sub;

    assign num_mag = i_num[31] ? (~i_num + 32'd1) : i_num;
    assign den_mag = i_den[31] ? (~i_den + 32'd1) : i_den;
    assign rem_sh  = {r_rem, r_dvd[NW-1]};
    assign take    = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd <= {num_mag, {FRAC_BITS{1'b0}}};
                r_rem <= '0;
                r_dvs <= den_mag;
                r_neg <= i_num[31] ^ i_den[31];
                r_cnt <= CNW'(NW);
            end else if (r_cnt != '0) begin
                // shift one dividend bit into the remainder, quotient bit in at the bottom
                r_rem  <= take ? rem_sub[31:0] : rem_sh[31:0];
                r_dvd  <= {r_dvd[NW-2:0], take};
                r_cnt  <= r_cnt - CNW'(1);
                r_done <= (r_cnt == CNW'(1));
            end
        end
    end

    logic hi_any;
    logic exact_min;
    assign hi_any    = |r_dvd[NW-1:31];
    assign exact_min = (r_dvd[NW-1:31] == {{(NW-32){1'b0}}, 1'b1}) && (r_dvd[30:0] == '0);

    always_comb begin
        o_sat  = 1'b0;
        o_quot = r_dvd[31:0];
        if (r_neg) begin
            if (hi_any && !exact_min) begin
                o_sat  = 1'b1;
                o_quot = SAT_MIN;
            end else begin
                o_quot = ~r_dvd[31:0] + 32'd1;
            end
        end else if (hi_any) begin
            o_sat  = 1'b1;
            o_quot = SAT_MAX;
        end
    end

    assign o_done = r_done;
endmodule

FILE: src/ptds_checker.sv
// Port-level checker for the Poisson tridiagonal solver, bound to the top.
// Depends on poisson_1d_tridiagonal_solver_unit port names only.
module ptds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_last_node,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_potential,
    input logic        o_last_potential
);
    // never take a word while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while output valid");

    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last_node) |=> !o_in_ready)
        else $error("ready after final node");

    a_mid_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_last_node) |=> o_in_ready)
        else $error("ready dropped after non-final node");

    a_end_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_potential) |=> (!o_out_valid && o_in_ready))
        else $error("not idle after final result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_potential)))
        else $error("stalled result changed");
endmodule

bind poisson_1d_tridiagonal_solver_unit ptds_checker u_ptds_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
    .i_last_node(i_last_node), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_potential(o_potential), .o_last_potential(o_last_potential)
);
